// ===== rtl/consistent_hash_ring_macros.svh =====
// Assertion macros shared by the checker.
`ifndef CONSISTENT_HASH_RING_MACROS_SVH
`define CONSISTENT_HASH_RING_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/chr_pkg.sv =====
package chr_pkg;
  localparam int unsigned ID_W = 17;
  localparam int unsigned PT_W = 32;
  localparam logic [PT_W-1:0] MIX_MUL = 32'h045d9f3b;
  localparam logic [PT_W-1:0] DJB_INIT = 32'd5381;
  localparam logic [ID_W-1:0] ID_STEP = 17'd100000;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_KEY = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_REMOVED = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DUP = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PRES_RD,
    S_PRES_CHK,
    S_DECIDE,
    S_MIX_A,
    S_MIX_B,
    S_MIX_C,
    S_MIX_D,
    S_MIX_E,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_NB_RD,
    S_NB_PREV,
    S_NB_SUCC,
    S_RM_RD,
    S_RM_CHK,
    S_LK_RD,
    S_LK_CHK,
    S_LK_WRAP,
    S_OUT
  } state_t;
endpackage

// ===== rtl/consistent_hash_ring.sv =====
// Consistent hash ring. A sorted ring of 32-bit points, REPLICAS per server, lives in two
// one-port-read synchronous memories (point and owning server) indexed by ring position.
// One item is worked at a time through a sequencer. An add first scans every point for the
// server. Then, for each replica, it runs a mixer and a linear search over the points. It
// shifts the tail up (a check, a read and a write-back per moved entry), then inserts the
// point and fetches its neighbors. A remove runs the same presence scan and then compacts
// the ring in place. A key byte that is not last is accumulated into the hash; the last
// byte also starts a search of the ring. Each result beat waits in an output register
// until taken; the next item is accepted once the final beat of the current item has gone.
// The memories need no clearing after reset: entries at or above the point count are never
// read.
module consistent_hash_ring #(
  parameter int unsigned MAX_SERVERS = 32,
  parameter int unsigned REPLICAS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] action,
  input  logic [chr_pkg::ID_W-1:0] server_ident,
  input  logic [7:0] key_byte,
  input  logic key_last,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] result_kind,
  output logic [chr_pkg::ID_W-1:0] owner_server,
  output logic [chr_pkg::ID_W-1:0] source_server,
  output logic range_valid,
  output logic [chr_pkg::PT_W-1:0] range_start,
  output logic [chr_pkg::PT_W-1:0] range_end,
  output logic [chr_pkg::PT_W-1:0] key_hash,
  output logic [2:0] status,
  output logic last
);
  import chr_pkg::*;

  localparam int unsigned DEPTH = MAX_SERVERS * REPLICAS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RW = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;

  // Ring storage.
  logic [PT_W-1:0] mem_point [DEPTH];
  logic [ID_W-1:0] mem_server [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic wr_en;
  logic [PT_W-1:0] wr_point;
  logic [ID_W-1:0] wr_server;
  logic [PT_W-1:0] rd_point;
  logic [ID_W-1:0] rd_server;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_point[wr_addr] <= wr_point;
      mem_server[wr_addr] <= wr_server;
    end
    rd_point <= mem_point[rd_addr];
    rd_server <= mem_server[rd_addr];
  end

  state_t state;
  state_t state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [PT_W-1:0] acc;
  logic [PT_W-1:0] acc_next;
  logic [1:0] act;
  logic [1:0] act_next;
  logic [ID_W-1:0] sid;
  logic [ID_W-1:0] sid_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] widx;
  logic [CW-1:0] widx_next;
  logic [RW-1:0] rep;
  logic [RW-1:0] rep_next;
  logic found;
  logic found_next;
  logic [PT_W-1:0] mx;
  logic [PT_W-1:0] mx_next;
  logic [PT_W-1:0] hsh;
  logic [PT_W-1:0] hsh_next;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_next;
  logic [PT_W-1:0] prev_pt;
  logic [PT_W-1:0] prev_pt_next;

  // Output register.
  logic ov;
  logic ov_next;
  logic [1:0] o_kind;
  logic [1:0] o_kind_next;
  logic [ID_W-1:0] o_owner;
  logic [ID_W-1:0] o_owner_next;
  logic [ID_W-1:0] o_src;
  logic [ID_W-1:0] o_src_next;
  logic o_rv;
  logic o_rv_next;
  logic [PT_W-1:0] o_start;
  logic [PT_W-1:0] o_start_next;
  logic [PT_W-1:0] o_end;
  logic [PT_W-1:0] o_end_next;
  logic [PT_W-1:0] o_hash;
  logic [PT_W-1:0] o_hash_next;
  logic [2:0] o_status;
  logic [2:0] o_status_next;
  logic o_last;
  logic o_last_next;

  logic out_free;
  logic in_acc;
  logic [PT_W-1:0] mix_x;
  logic [PT_W-1:0] acc_sum;

  assign out_free = !ov || !out_stall;
  assign in_stall = (state != S_IDLE) || ov;
  assign in_acc = in_valid && !in_stall;
  assign mix_x = (mx >> 16) ^ mx;
  assign acc_sum = (acc << 5) + acc + {24'd0, key_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      acc <= DJB_INIT;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      acc <= acc_next;
      ov <= ov_next;
    end
    act <= act_next;
    sid <= sid_next;
    idx <= idx_next;
    widx <= widx_next;
    rep <= rep_next;
    found <= found_next;
    mx <= mx_next;
    hsh <= hsh_next;
    pos <= pos_next;
    prev_pt <= prev_pt_next;
    o_kind <= o_kind_next;
    o_owner <= o_owner_next;
    o_src <= o_src_next;
    o_rv <= o_rv_next;
    o_start <= o_start_next;
    o_end <= o_end_next;
    o_hash <= o_hash_next;
    o_status <= o_status_next;
    o_last <= o_last_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    acc_next = acc;
    act_next = act;
    sid_next = sid;
    idx_next = idx;
    widx_next = widx;
    rep_next = rep;
    found_next = found;
    mx_next = mx;
    hsh_next = hsh;
    pos_next = pos;
    prev_pt_next = prev_pt;
    ov_next = ov && out_stall;
    o_kind_next = o_kind;
    o_owner_next = o_owner;
    o_src_next = o_src;
    o_rv_next = o_rv;
    o_start_next = o_start;
    o_end_next = o_end;
    o_hash_next = o_hash;
    o_status_next = o_status;
    o_last_next = o_last;
    rd_addr = idx[AW-1:0];
    wr_en = 1'b0;
    wr_addr = widx[AW-1:0];
    wr_point = rd_point;
    wr_server = rd_server;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          act_next = action;
          sid_next = server_ident;
          idx_next = '0;
          found_next = 1'b0;
          rep_next = '0;
          case (action)
            ACT_ADD, ACT_REMOVE: state_next = S_PRES_RD;
            ACT_KEY: begin
              acc_next = acc_sum;
              if (key_last) begin
                hsh_next = acc_sum;
                acc_next = DJB_INIT;
                state_next = S_LK_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      // Presence scan over all points.
      S_PRES_RD: begin
        if (idx >= count) state_next = S_DECIDE;
        else state_next = S_PRES_CHK;
      end
      S_PRES_CHK: begin
        if (rd_server == sid) found_next = 1'b1;
        idx_next = idx + 1'b1;
        state_next = S_PRES_RD;
      end
      S_DECIDE: begin
        o_owner_next = sid;
        o_src_next = '0;
        o_rv_next = 1'b0;
        o_start_next = '0;
        o_end_next = '0;
        o_hash_next = '0;
        o_last_next = 1'b1;
        if (act == ACT_ADD) begin
          if (found || (32'(count) + REPLICAS > DEPTH)) begin
            o_kind_next = KIND_REJECT;
            o_status_next = found ? ST_DUP : ST_FULL;
            state_next = S_OUT;
          end else begin
            mx_next = 32'(sid);
            state_next = S_MIX_A;
          end
        end else begin
          if (!found) begin
            o_kind_next = KIND_REJECT;
            o_status_next = ST_UNKNOWN;
            state_next = S_OUT;
          end else begin
            idx_next = '0;
            widx_next = '0;
            state_next = S_RM_RD;
          end
        end
      end
      // Mixer: at most one multiply per step, registered between steps.
      S_MIX_A: begin
        mx_next = mx + 32'(rep) * 32'(ID_STEP);
        state_next = S_MIX_B;
      end
      S_MIX_B: begin
        mx_next = mix_x * MIX_MUL;
        state_next = S_MIX_C;
      end
      S_MIX_C: begin
        mx_next = mix_x * MIX_MUL;
        state_next = S_MIX_D;
      end
      S_MIX_D: begin
        mx_next = mix_x;
        idx_next = '0;
        state_next = S_FIND_RD;
      end
      // Search the first point at or above the new one.
      S_FIND_RD: begin
        if (idx >= count) begin
          pos_next = idx;
          idx_next = count;
          state_next = S_MIX_E;
        end else state_next = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (rd_point < mx) begin
          idx_next = idx + 1'b1;
          state_next = S_FIND_RD;
        end else begin
          pos_next = idx;
          idx_next = count;
          state_next = S_MIX_E;
        end
      end
      // Shift the tail up by one, from the top down.
      S_MIX_E: begin
        if (idx > pos) begin
          idx_next = idx - 1'b1;
          state_next = S_SHIFT_RD;
        end else state_next = S_INS_WR;
      end
      S_SHIFT_RD: begin
        widx_next = idx + 1'b1;
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
        state_next = S_MIX_E;
      end
      S_INS_WR: begin
        wr_en = 1'b1;
        wr_addr = pos[AW-1:0];
        wr_point = mx;
        wr_server = sid;
        count_next = count + 1'b1;
        idx_next = (pos == '0) ? count : pos - 1'b1;
        state_next = S_NB_RD;
      end
      S_NB_RD: begin
        state_next = S_NB_PREV;
      end
      // The successor read is issued here so its data is ready in the next state.
      S_NB_PREV: begin
        prev_pt_next = rd_point;
        idx_next = (pos + 1'b1 < count) ? pos + 1'b1 : '0;
        rd_addr = idx_next[AW-1:0];
        state_next = S_NB_SUCC;
      end
      // While the output register is busy, the successor is simply read again.
      S_NB_SUCC: begin
        if (out_free) begin
          o_kind_next = KIND_RANGE;
          o_owner_next = sid;
          o_src_next = rd_server;
          o_rv_next = rd_server != sid;
          o_start_next = prev_pt;
          o_end_next = mx;
          o_hash_next = '0;
          o_status_next = ST_OK;
          o_last_next = (32'(rep) + 1 == REPLICAS);
          ov_next = 1'b1;
          if (32'(rep) + 1 == REPLICAS) state_next = S_IDLE;
          else begin
            rep_next = rep + 1'b1;
            mx_next = 32'(sid);
            state_next = S_MIX_A;
          end
        end
      end
      // Compact the ring, dropping the removed server.
      S_RM_RD: begin
        if (idx >= count) begin
          count_next = widx;
          o_kind_next = KIND_REMOVED;
          o_status_next = ST_OK;
          state_next = S_OUT;
        end else state_next = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (rd_server != sid) begin
          wr_en = 1'b1;
          widx_next = widx + 1'b1;
        end
        idx_next = idx + 1'b1;
        state_next = S_RM_RD;
      end
      // Lookup.
      S_LK_RD: begin
        o_src_next = '0;
        o_rv_next = 1'b0;
        o_start_next = '0;
        o_end_next = '0;
        o_hash_next = hsh;
        o_last_next = 1'b1;
        if (count == '0) begin
          o_kind_next = KIND_REJECT;
          o_owner_next = '0;
          o_status_next = ST_EMPTY;
          state_next = S_OUT;
        end else if (idx >= count) begin
          idx_next = '0;
          state_next = S_LK_WRAP;
        end else state_next = S_LK_CHK;
      end
      S_LK_CHK: begin
        if (rd_point < hsh) begin
          idx_next = idx + 1'b1;
          state_next = S_LK_RD;
        end else begin
          o_kind_next = KIND_LOOKUP;
          o_owner_next = rd_server;
          o_status_next = ST_OK;
          state_next = S_OUT;
        end
      end
      S_LK_WRAP: begin
        state_next = S_LK_CHK;
        hsh_next = '0;
        o_hash_next = hsh;
      end
      S_OUT: begin
        if (out_free) begin
          ov_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = ov;
  assign result_kind = o_kind;
  assign owner_server = o_owner;
  assign source_server = o_src;
  assign range_valid = o_rv;
  assign range_start = o_start;
  assign range_end = o_end;
  assign key_hash = o_hash;
  assign status = o_status;
  assign last = o_last;
endmodule

// ===== rtl/chr_checker.sv =====
module chr_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] result_kind,
  input logic range_valid,
  input logic [2:0] status,
  input logic last
);
  `include "consistent_hash_ring_macros.svh"
  import chr_pkg::*;

  `CHR_ASSERT_IMPL(a_reject_status, clk, rst,
    out_valid && result_kind == KIND_REJECT, status != ST_OK && last,
    "reject without error status")
  `CHR_ASSERT_IMPL(a_ok_status, clk, rst,
    out_valid && result_kind != KIND_REJECT, status == ST_OK,
    "ok result with error status")
  `CHR_ASSERT_IMPL(a_range_only_add, clk, rst,
    out_valid && range_valid, result_kind == KIND_RANGE,
    "range on non-add result")
  `CHR_ASSERT_IMPL(a_busy_with_result, clk, rst,
    out_valid, in_stall,
    "input open while a result beat waits")
  `CHR_ASSERT_NEXT(a_out_hold, clk, rst,
    out_valid && out_stall, out_valid && $stable(result_kind),
    "result dropped while stalled")
endmodule

bind consistent_hash_ring chr_checker u_chr_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
  .range_valid(range_valid), .status(status), .last(last)
);
